[hw/rtl/thermal_fan_step_controller_assert.svh]
// Assertion macros for the thermal fan step controller.
// Both sample on clk_i and are disabled while rst_ni is low.
`ifndef THERMAL_FAN_STEP_CONTROLLER_ASSERT_SVH
`define THERMAL_FAN_STEP_CONTROLLER_ASSERT_SVH

// Same-cycle implication
`define TFSC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define TFSC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/tfsc_pkg.sv]
// Package for the thermal fan step controller: widths, register codes,
// config/state/result structs and the level selection function. No dependencies.
package tfsc_pkg;

  localparam int COUNT_BITS   = 8;
  localparam int TEMP_BITS    = 7;
  localparam int CFG_IDX_BITS = 4;
  localparam int CFG_DAT_BITS = 8;

  // Register indexes of the configuration port
  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_EVAL_TICKS    = 4'd0,
    REG_CHECK_TICKS   = 4'd1,
    REG_HOLDOFF_TICKS = 4'd2,
    REG_JUMP_DELTA    = 4'd3,
    REG_TEMP_LOW      = 4'd4,
    REG_TEMP_MID      = 4'd5,
    REG_TEMP_HIGH     = 4'd6,
    REG_POLICY_BITS   = 4'd7
  } tfsc_reg_e;

  // Reset values of the registers
  localparam logic [7:0] RST_EVAL_TICKS    = 8'd10;
  localparam logic [7:0] RST_CHECK_TICKS   = 8'd10;
  localparam logic [7:0] RST_HOLDOFF_TICKS = 8'd20;
  localparam logic [6:0] RST_JUMP_DELTA    = 7'd5;
  localparam logic [6:0] RST_TEMP_LOW      = 7'd45;
  localparam logic [6:0] RST_TEMP_MID      = 7'd60;
  localparam logic [6:0] RST_TEMP_HIGH     = 7'd80;
  localparam logic [7:0] RST_POLICY_BITS   = 8'd36;

  typedef struct packed {
    logic [7:0] eval_ticks;
    logic [7:0] check_ticks;
    logic [7:0] holdoff_ticks;
    logic [6:0] jump_delta;
    logic [6:0] temp_low;
    logic [6:0] temp_mid;
    logic [6:0] temp_high;
    logic [7:0] policy_bits;
  } tfsc_cfg_t;

  typedef struct packed {
    logic [COUNT_BITS-1:0] period_cnt;
    logic [COUNT_BITS-1:0] check_cnt;
    logic [COUNT_BITS-1:0] hold_cnt;
    logic [TEMP_BITS-1:0]  last_temp;
    logic                  base_valid;
    logic [1:0]            target_level;
    logic [1:0]            latched_fan;
    logic [1:0]            last_cmd;
    logic                  last_cmd_valid;
  } tfsc_state_t;

  typedef struct packed {
    logic                 cmd_valid;
    logic [1:0]           cmd_level;
    logic                 sampled;
    logic                 holdoff_active;
    logic [TEMP_BITS-1:0] held_temp;
    logic [1:0]           held_fan;
  } tfsc_result_t;

  // Saturating decrement of a pacing counter
  function automatic logic [COUNT_BITS-1:0] dec_sat(input logic [COUNT_BITS-1:0] c);
    return (c == '0) ? c : c - COUNT_BITS'(1);
  endfunction

  // Target level from the thresholds, default or boundary-only mode
  function automatic logic [1:0] choose_level(input logic [TEMP_BITS-1:0] t,
                                              input logic [1:0] target,
                                              input logic [1:0] latched,
                                              input tfsc_cfg_t cfg);
    logic [1:0]           lo_fan;
    logic [1:0]           mid_fan;
    logic [1:0]           hi_fan;
    logic [TEMP_BITS-1:0] t_lo;
    logic [TEMP_BITS-1:0] t_mid;
    logic [TEMP_BITS-1:0] t_hi;
    logic [1:0]           lvl;
    lo_fan  = cfg.policy_bits[1:0];
    mid_fan = cfg.policy_bits[3:2];
    hi_fan  = cfg.policy_bits[5:4];
    t_lo    = TEMP_BITS'(cfg.temp_low);
    t_mid   = TEMP_BITS'(cfg.temp_mid);
    t_hi    = TEMP_BITS'(cfg.temp_high);
    lvl     = target;
    if (cfg.policy_bits[6]) begin
      if (t <= t_lo && latched > lo_fan) begin
        lvl = lo_fan;
      end else if (t >= t_hi && latched < hi_fan) begin
        lvl = hi_fan;
      end else begin
        lvl = latched;
      end
    end else begin
      if (t <= t_lo) begin
        lvl = lo_fan;
      end else if (t > t_hi) begin
        lvl = hi_fan;
      end else if (t >= t_mid && target < mid_fan) begin
        lvl = mid_fan;
      end
    end
    return lvl;
  endfunction

endpackage

[hw/rtl/tfsc_if.sv]
// Channel interfaces of the thermal fan step controller: tick words in,
// result words out, register writes. Depends on tfsc_pkg.

interface tfsc_tick_if;
  import tfsc_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [TEMP_BITS-1:0] temp_sample;
  logic [1:0]           fan_reading;
  modport source (output valid, temp_sample, fan_reading, input ready);
  modport sink   (input valid, temp_sample, fan_reading, output ready);
endinterface

interface tfsc_res_if;
  import tfsc_pkg::*;
  logic                 valid;
  logic                 ready;
  logic                 cmd_valid;
  logic [1:0]           cmd_level;
  logic                 sampled;
  logic                 holdoff_active;
  logic [TEMP_BITS-1:0] held_temp;
  logic [1:0]           held_fan;
  modport source (output valid, cmd_valid, cmd_level, sampled, holdoff_active,
                  held_temp, held_fan, input ready);
  modport sink   (input valid, cmd_valid, cmd_level, sampled, holdoff_active,
                  held_temp, held_fan, output ready);
endinterface

interface tfsc_cfg_if;
  import tfsc_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [CFG_IDX_BITS-1:0] index;
  logic [CFG_DAT_BITS-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[hw/rtl/thermal_fan_step_controller.sv]
// Thermal fan step controller. Each tick word carries a temperature and a
// fan reading and yields exactly one result word. The block takes one word
// per cycle while the result side accepts; result back-pressure stalls it. A
// tick passes through the input register, then one pass of tick logic into the
// result register, which updates the state once per tick. Register writes
// belong in idle periods.
// Depends on tfsc_pkg, tfsc_if, tfsc_cfg_regs, tfsc_step and the assert header.
`include "thermal_fan_step_controller_assert.svh"

module thermal_fan_step_controller (
  input  logic       clk_i,
  input  logic       rst_ni,
  tfsc_tick_if.sink  tick_i,
  tfsc_res_if.source res_o,
  tfsc_cfg_if.sink   cfg_i
);
  import tfsc_pkg::*;

  tfsc_cfg_t            cfg;
  tfsc_state_t          state_d, state_q;
  tfsc_result_t         res_d, res_q;
  logic                 in_valid_d, in_valid_q;
  logic [TEMP_BITS-1:0] in_temp_q;
  logic [1:0]           in_fan_q;
  logic                 res_valid_d, res_valid_q;
  logic                 advance;

  tfsc_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  tfsc_step u_step (
    .cfg_i    (cfg),
    .state_i  (state_q),
    .temp_i   (in_temp_q),
    .fan_i    (in_fan_q),
    .state_o  (state_d),
    .result_o (res_d)
  );

  // Handshake: input stage moves on when the result register is free or its word is taken
  assign advance      = in_valid_q && (!res_valid_q || res_o.ready);
  assign tick_i.ready = !in_valid_q || advance;

  always_comb begin
    in_valid_d = in_valid_q;
    if (tick_i.valid && tick_i.ready) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
    res_valid_d = res_valid_q;
    if (advance) begin
      res_valid_d = 1'b1;
    end else if (res_o.ready) begin
      res_valid_d = 1'b0;
    end
  end

  // Control and state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      res_valid_q <= 1'b0;
      state_q     <= '0;
    end else begin
      in_valid_q  <= in_valid_d;
      res_valid_q <= res_valid_d;
      if (advance) begin
        state_q <= state_d;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (tick_i.valid && tick_i.ready) begin
      in_temp_q <= tick_i.temp_sample;
      in_fan_q  <= tick_i.fan_reading;
    end
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign res_o.valid          = res_valid_q;
  assign res_o.cmd_valid      = res_q.cmd_valid;
  assign res_o.cmd_level      = res_q.cmd_level;
  assign res_o.sampled        = res_q.sampled;
  assign res_o.holdoff_active = res_q.holdoff_active;
  assign res_o.held_temp      = res_q.held_temp;
  assign res_o.held_fan       = res_q.held_fan;

  // Checks
  `TFSC_ASSERT_IMP(a_cmd_differs, res_valid_q && res_q.cmd_valid,
                   res_q.cmd_level != res_q.held_fan, "command equals latched fan")
  `TFSC_ASSERT_IMP(a_idle_level, res_valid_q && !res_q.cmd_valid,
                   res_q.cmd_level == 2'd0, "level without command")
  `TFSC_ASSERT_IMP(a_stall_full, !tick_i.ready,
                   in_valid_q && res_valid_q && !res_o.ready, "stall with room")
  `TFSC_ASSERT_NXT(a_advance_res, advance,
                   res_valid_q, "advanced word lost")

endmodule

[hw/rtl/tfsc_cfg_regs.sv]
// Configuration register bank of the thermal fan step controller.
// Depends on tfsc_pkg and tfsc_cfg_if.
module tfsc_cfg_regs (
  input  logic                clk_i,
  input  logic                rst_ni,
  tfsc_cfg_if.sink            cfg_i,
  output tfsc_pkg::tfsc_cfg_t cfg_o
);
  import tfsc_pkg::*;

  tfsc_cfg_t cfg_d, cfg_q;

  // Writes are always accepted
  assign cfg_i.ready = 1'b1;

  // Decode the register index; unknown indexes are dropped
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_EVAL_TICKS:    cfg_d.eval_ticks    = cfg_i.data;
        REG_CHECK_TICKS:   cfg_d.check_ticks   = cfg_i.data;
        REG_HOLDOFF_TICKS: cfg_d.holdoff_ticks = cfg_i.data;
        REG_JUMP_DELTA:    cfg_d.jump_delta    = cfg_i.data[6:0];
        REG_TEMP_LOW:      cfg_d.temp_low      = cfg_i.data[6:0];
        REG_TEMP_MID:      cfg_d.temp_mid      = cfg_i.data[6:0];
        REG_TEMP_HIGH:     cfg_d.temp_high     = cfg_i.data[6:0];
        REG_POLICY_BITS:   cfg_d.policy_bits   = cfg_i.data;
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.eval_ticks    <= RST_EVAL_TICKS;
      cfg_q.check_ticks   <= RST_CHECK_TICKS;
      cfg_q.holdoff_ticks <= RST_HOLDOFF_TICKS;
      cfg_q.jump_delta    <= RST_JUMP_DELTA;
      cfg_q.temp_low      <= RST_TEMP_LOW;
      cfg_q.temp_mid      <= RST_TEMP_MID;
      cfg_q.temp_high     <= RST_TEMP_HIGH;
      cfg_q.policy_bits   <= RST_POLICY_BITS;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

[hw/rtl/tfsc_step.sv]
// Per-tick update of the thermal fan step controller: counters, fan latch,
// sampling, jump hold-off, level choice and command issue. Depends on tfsc_pkg.
module tfsc_step (
  input  tfsc_pkg::tfsc_cfg_t                 cfg_i,
  input  tfsc_pkg::tfsc_state_t               state_i,
  input  logic [tfsc_pkg::TEMP_BITS-1:0]      temp_i,
  input  logic [1:0]                          fan_i,
  output tfsc_pkg::tfsc_state_t               state_o,
  output tfsc_pkg::tfsc_result_t              result_o
);
  import tfsc_pkg::*;

  tfsc_state_t          nxt;
  logic                 mon_only;
  logic                 sampled;
  logic                 issue;
  logic                 rise;
  logic [TEMP_BITS-1:0] prev;

  assign mon_only = cfg_i.policy_bits[7];

  always_comb begin
    nxt     = state_i;
    sampled = 1'b0;
    issue   = 1'b0;
    rise    = 1'b0;
    prev    = temp_i;

    // every counter steps down first
    nxt.period_cnt = dec_sat(state_i.period_cnt);
    nxt.check_cnt  = dec_sat(state_i.check_cnt);
    nxt.hold_cnt   = dec_sat(state_i.hold_cnt);

    if (!(nxt.period_cnt != '0 && (nxt.check_cnt != '0 || mon_only))) begin
      // fan check tick: latch reading, clear a command it confirms
      if (nxt.check_cnt == '0) begin
        nxt.check_cnt   = COUNT_BITS'(cfg_i.check_ticks);
        nxt.latched_fan = fan_i;
        if (nxt.last_cmd_valid && fan_i == nxt.last_cmd) begin
          nxt.last_cmd_valid = 1'b0;
        end
      end
      // temperature period tick
      if (nxt.period_cnt == '0) begin
        nxt.period_cnt     = COUNT_BITS'(cfg_i.eval_ticks);
        nxt.last_cmd_valid = 1'b0;
        sampled            = 1'b1;
        if (nxt.hold_cnt == '0) begin
          // first sample is its own baseline
          prev           = state_i.base_valid ? state_i.last_temp : temp_i;
          nxt.last_temp  = temp_i;
          nxt.base_valid = 1'b1;
          rise = (temp_i > prev) && ((temp_i - prev) > TEMP_BITS'(cfg_i.jump_delta));
          if (rise && !mon_only) begin
            nxt.hold_cnt = COUNT_BITS'(cfg_i.holdoff_ticks);
          end else begin
            nxt.target_level = choose_level(temp_i, nxt.target_level,
                                            nxt.latched_fan, cfg_i);
          end
        end
      end
      // issue a set command when the target is new and differs from the latched fan, unless monitor-only
      if ((!nxt.last_cmd_valid || nxt.target_level != nxt.last_cmd) &&
          nxt.target_level != nxt.latched_fan && !mon_only) begin
        nxt.last_cmd       = nxt.target_level;
        nxt.last_cmd_valid = 1'b1;
        issue              = 1'b1;
      end
    end
  end

  assign state_o                 = nxt;
  assign result_o.cmd_valid      = issue;
  assign result_o.cmd_level      = issue ? nxt.target_level : 2'd0;
  assign result_o.sampled        = sampled;
  assign result_o.holdoff_active = (nxt.hold_cnt != '0);
  assign result_o.held_temp      = nxt.last_temp;
  assign result_o.held_fan       = nxt.latched_fan;

endmodule

[tb/tfsc_step_checker.sv]
`timescale 1ns / 1ps
// Checker for the thermal fan step controller: follows register writes and tick
// words, predicts each result word and compares it. Depends on tfsc_pkg, tfsc_if.

module tfsc_step_checker (
  input  logic clk_i,
  input  logic rst_ni,
  tfsc_tick_if tick,
  tfsc_res_if  res,
  tfsc_cfg_if  cfg_ch,
  output int   fail_count,
  output int   pending_words,
  output int   words_checked,
  output int   cmds_seen
);
  import tfsc_pkg::*;

  // Shadow registers and controller state
  tfsc_cfg_t             shadow;
  logic [COUNT_BITS-1:0] period_cnt;
  logic [COUNT_BITS-1:0] check_cnt;
  logic [COUNT_BITS-1:0] hold_cnt;
  logic [TEMP_BITS-1:0]  last_temp;
  logic                  base_valid;
  logic [1:0]            target_lvl;
  logic [1:0]            latched;
  logic [1:0]            last_cmd;
  logic                  cmd_pending;

  tfsc_result_t expected_words[$];
  tfsc_result_t got;
  tfsc_result_t want;

  // One tick of the controller: updates the shadow state, returns the result word
  function automatic tfsc_result_t advance_tick(input logic [TEMP_BITS-1:0] t,
                                                input logic [1:0] fan);
    tfsc_result_t r;
    logic         mon_only;
    logic         did_sample;
    logic         issue;
    logic [1:0]   lo_fan;
    logic [1:0]   mid_fan;
    logic [1:0]   hi_fan;
    int           prev_t;
    mon_only   = shadow.policy_bits[7];
    lo_fan     = shadow.policy_bits[1:0];
    mid_fan    = shadow.policy_bits[3:2];
    hi_fan     = shadow.policy_bits[5:4];
    did_sample = 1'b0;
    issue      = 1'b0;

    // all pacing counters step down first
    if (period_cnt != '0) period_cnt = period_cnt - 1'b1;
    if (check_cnt != '0) check_cnt = check_cnt - 1'b1;
    if (hold_cnt != '0) hold_cnt = hold_cnt - 1'b1;

    if (period_cnt == '0 || (check_cnt == '0 && !mon_only)) begin
      // fan check: latch the reading, a matching reading retires the pending command
      if (check_cnt == '0) begin
        check_cnt = shadow.check_ticks;
        latched   = fan;
        if (cmd_pending && latched == last_cmd) cmd_pending = 1'b0;
      end
      // temperature period
      if (period_cnt == '0) begin
        period_cnt  = shadow.eval_ticks;
        cmd_pending = 1'b0;
        did_sample  = 1'b1;
        if (hold_cnt == '0) begin
          // first sample is its own baseline
          prev_t     = base_valid ? int'(last_temp) : int'(t);
          last_temp  = t;
          base_valid = 1'b1;
          if (int'(t) - prev_t > int'(shadow.jump_delta) && !mon_only) begin
            hold_cnt = shadow.holdoff_ticks;
          end else if (shadow.policy_bits[6]) begin
            // boundary mode: only move at the outer thresholds
            if (t <= shadow.temp_low && latched > lo_fan) begin
              target_lvl = lo_fan;
            end else if (t >= shadow.temp_high && latched < hi_fan) begin
              target_lvl = hi_fan;
            end else begin
              target_lvl = latched;
            end
          end else begin
            if (t <= shadow.temp_low) begin
              target_lvl = lo_fan;
            end else if (t > shadow.temp_high) begin
              target_lvl = hi_fan;
            end else if (t >= shadow.temp_mid && target_lvl < mid_fan) begin
              target_lvl = mid_fan;
            end
          end
        end
      end
      if ((!cmd_pending || target_lvl != last_cmd) && target_lvl != latched && !mon_only) begin
        last_cmd    = target_lvl;
        cmd_pending = 1'b1;
        issue       = 1'b1;
      end
    end

    r.cmd_valid      = issue;
    r.cmd_level      = issue ? target_lvl : 2'd0;
    r.sampled        = did_sample;
    r.holdoff_active = (hold_cnt != '0);
    r.held_temp      = last_temp;
    r.held_fan       = latched;
    return r;
  endfunction

  // Track writes, check result words, then predict the new tick word
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shadow.eval_ticks    = RST_EVAL_TICKS;
      shadow.check_ticks   = RST_CHECK_TICKS;
      shadow.holdoff_ticks = RST_HOLDOFF_TICKS;
      shadow.jump_delta    = RST_JUMP_DELTA;
      shadow.temp_low      = RST_TEMP_LOW;
      shadow.temp_mid      = RST_TEMP_MID;
      shadow.temp_high     = RST_TEMP_HIGH;
      shadow.policy_bits   = RST_POLICY_BITS;
      period_cnt    = '0;
      check_cnt     = '0;
      hold_cnt      = '0;
      last_temp     = '0;
      base_valid    = 1'b0;
      target_lvl    = 2'd0;
      latched       = 2'd0;
      last_cmd      = 2'd0;
      cmd_pending   = 1'b0;
      expected_words.delete();
      fail_count    = 0;
      words_checked = 0;
      cmds_seen     = 0;
      pending_words = 0;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (tfsc_reg_e'(cfg_ch.index))
          REG_EVAL_TICKS:    shadow.eval_ticks    = cfg_ch.data;
          REG_CHECK_TICKS:   shadow.check_ticks   = cfg_ch.data;
          REG_HOLDOFF_TICKS: shadow.holdoff_ticks = cfg_ch.data;
          REG_JUMP_DELTA:    shadow.jump_delta    = cfg_ch.data[6:0];
          REG_TEMP_LOW:      shadow.temp_low      = cfg_ch.data[6:0];
          REG_TEMP_MID:      shadow.temp_mid      = cfg_ch.data[6:0];
          REG_TEMP_HIGH:     shadow.temp_high     = cfg_ch.data[6:0];
          REG_POLICY_BITS:   shadow.policy_bits   = cfg_ch.data;
          default: ;
        endcase
      end

      if (res.valid && res.ready) begin
        got.cmd_valid      = res.cmd_valid;
        got.cmd_level      = res.cmd_level;
        got.sampled        = res.sampled;
        got.holdoff_active = res.holdoff_active;
        got.held_temp      = res.held_temp;
        got.held_fan       = res.held_fan;
        if (got.cmd_valid === 1'b1) cmds_seen++;
        if (expected_words.size() == 0) begin
          if (fail_count < 10) $display("result word %0d arrived with none expected",
                                        words_checked);
          fail_count++;
        end else begin
          want = expected_words.pop_front();
          if (got !== want) begin
            if (fail_count < 10) begin
              $display("result word %0d mismatch: expected cmd %0b/%0d smp %0b hold %0b",
                       words_checked, want.cmd_valid, want.cmd_level, want.sampled,
                       want.holdoff_active);
              $display("  temp %0d fan %0d; got cmd %0b/%0d smp %0b hold %0b temp %0d fan %0d",
                       want.held_temp, want.held_fan, got.cmd_valid, got.cmd_level,
                       got.sampled, got.holdoff_active, got.held_temp, got.held_fan);
            end
            fail_count++;
          end
        end
        words_checked++;
      end

      if (tick.valid && tick.ready) begin
        expected_words.push_back(advance_tick(tick.temp_sample, tick.fan_reading));
      end
      pending_words = expected_words.size();
    end
  end

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps
// Top of the thermal fan step controller testbench: clock, reset, tick and
// register stimulus, verdict. Depends on tfsc_pkg, tfsc_if, tfsc_step_checker, the block.

module tb_top;
  import tfsc_pkg::*;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  tfsc_tick_if tick_ch();
  tfsc_res_if  res_ch();
  tfsc_cfg_if  cfg_ch();

  int fail_count;
  int pending_words;
  int words_checked;
  int cmds_seen;

  int tick_gap_pct  = 16;
  int res_stall_pct = 51;
  int ticks_sent    = 0;
  int settings_used = 0;
  int temp_walk     = 60;

  logic [1:0] fan_follow = 2'd0;
  tfsc_cfg_t  cur_setting;

  thermal_fan_step_controller dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .tick_i (tick_ch),
    .res_o  (res_ch),
    .cfg_i  (cfg_ch)
  );

  tfsc_step_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .tick          (tick_ch),
    .res           (res_ch),
    .cfg_ch        (cfg_ch),
    .fail_count    (fail_count),
    .pending_words (pending_words),
    .words_checked (words_checked),
    .cmds_seen     (cmds_seen)
  );

  // 12 ns clock
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Result side back-pressure
  initial begin
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      res_ch.ready <= ($urandom_range(0, 99) >= res_stall_pct);
    end
  end

  // The monitored fan mostly follows the last command issued
  always @(posedge clk_i) begin
    if (res_ch.valid && res_ch.ready && res_ch.cmd_valid) fan_follow <= res_ch.cmd_level;
  end

  // Hard stop
  initial begin
    #2000000;
    $display("Some tests failed");
    $finish;
  end

  // Send one tick word; valid stays high afterwards so back-to-back words never toggle it
  task automatic send_tick(input logic [TEMP_BITS-1:0] t, input logic [1:0] f);
    while ($urandom_range(0, 99) < tick_gap_pct) begin
      tick_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    tick_ch.valid       <= 1'b1;
    tick_ch.temp_sample <= t;
    tick_ch.fan_reading <= f;
    do @(posedge clk_i); while (!tick_ch.ready);
    ticks_sent++;
  endtask

  // Hold the sender until every result word is back, then let the pipeline settle
  task automatic drain();
    tick_ch.valid <= 1'b0;
    do @(posedge clk_i); while (pending_words != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input tfsc_reg_e idx, input logic [7:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk_i); while (!cfg_ch.ready);
  endtask

  // Program all eight registers while the block is idle
  task automatic apply_setting(input tfsc_cfg_t s);
    drain();
    write_reg(REG_EVAL_TICKS, s.eval_ticks);
    write_reg(REG_CHECK_TICKS, s.check_ticks);
    write_reg(REG_HOLDOFF_TICKS, s.holdoff_ticks);
    write_reg(REG_JUMP_DELTA, {1'b0, s.jump_delta});
    write_reg(REG_TEMP_LOW, {1'b0, s.temp_low});
    write_reg(REG_TEMP_MID, {1'b0, s.temp_mid});
    write_reg(REG_TEMP_HIGH, {1'b0, s.temp_high});
    write_reg(REG_POLICY_BITS, s.policy_bits);
    cfg_ch.valid <= 1'b0;
    cur_setting = s;
    settings_used++;
  endtask

  // Short pacing so samples come often; thresholds mostly ordered
  function automatic tfsc_cfg_t random_setting();
    tfsc_cfg_t  c;
    logic [6:0] a;
    logic [6:0] b;
    logic [6:0] x;
    logic [6:0] sw;
    a = 7'($urandom_range(10, 120));
    b = 7'($urandom_range(10, 120));
    x = 7'($urandom_range(10, 120));
    if ($urandom_range(0, 3) != 0) begin
      if (a > b) begin sw = a; a = b; b = sw; end
      if (b > x) begin sw = b; b = x; x = sw; end
      if (a > b) begin sw = a; a = b; b = sw; end
    end
    c.eval_ticks    = 8'($urandom_range(1, 4));
    c.check_ticks   = 8'($urandom_range(1, 6));
    c.holdoff_ticks = 8'($urandom_range(1, 12));
    c.jump_delta    = 7'($urandom_range(0, 20));
    c.temp_low      = a;
    c.temp_mid      = b;
    c.temp_high     = x;
    c.policy_bits   = 8'($urandom_range(0, 255));
    if ($urandom_range(0, 3) != 0) c.policy_bits[7] = 1'b0;
    return c;
  endfunction

  initial begin
    tfsc_cfg_t s;
    int        r;
    int        f;
    tick_ch.valid       <= 1'b0;
    tick_ch.temp_sample <= '0;
    tick_ch.fan_reading <= 2'd0;
    cfg_ch.valid        <= 1'b0;
    cfg_ch.index        <= REG_EVAL_TICKS;
    cfg_ch.data         <= 8'd0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: the first sample becomes its own baseline, however hot
    send_tick(7'd127, 2'd0);
    send_tick(7'd127, 2'd2);
    send_tick(7'd0, 2'd1);

    // Every tick samples and latches: jump edge, hold-off, threshold edges, fall
    s = '{eval_ticks: 8'd1, check_ticks: 8'd1, holdoff_ticks: 8'd3, jump_delta: 7'd5,
          temp_low: 7'd45, temp_mid: 7'd60, temp_high: 7'd80, policy_bits: 8'd41};
    apply_setting(s);
    send_tick(7'd0, 2'd0);
    send_tick(7'd5, 2'd1);
    send_tick(7'd11, 2'd2);
    send_tick(7'd11, 2'd3);
    send_tick(7'd127, 2'd0);
    send_tick(7'd127, 2'd1);
    send_tick(7'd45, 2'd0);
    send_tick(7'd46, 2'd1);
    send_tick(7'd60, 2'd2);
    send_tick(7'd59, 2'd3);
    send_tick(7'd80, 2'd0);
    send_tick(7'd81, 2'd1);
    send_tick(7'd100, 2'd2);

    // Zero registers: events on every tick, hold-off never runs; boundary mode
    s = '{eval_ticks: 8'd0, check_ticks: 8'd0, holdoff_ticks: 8'd0, jump_delta: 7'd0,
          temp_low: 7'd0, temp_mid: 7'd0, temp_high: 7'd0, policy_bits: 8'd120};
    apply_setting(s);
    send_tick(7'd0, 2'd3);
    send_tick(7'd1, 2'd0);
    send_tick(7'd2, 2'd1);
    send_tick(7'd127, 2'd2);
    send_tick(7'd0, 2'd0);

    // Monitor-only: no commands, no jump detection, levels still track
    s = '{eval_ticks: 8'd2, check_ticks: 8'd3, holdoff_ticks: 8'd5, jump_delta: 7'd3,
          temp_low: 7'd30, temp_mid: 7'd50, temp_high: 7'd70, policy_bits: 8'hA6};
    apply_setting(s);
    send_tick(7'd20, 2'd1);
    send_tick(7'd90, 2'd2);
    send_tick(7'd10, 2'd0);
    send_tick(7'd64, 2'd3);
    send_tick(7'd127, 2'd1);

    // Random phases: temperature random walk with occasional jumps and full-range values
    for (int p = 0; p < 6; p++) begin
      if (p == 2) begin
        tick_gap_pct  = 51;
        res_stall_pct = 16;
      end
      if (p == 4) begin
        tick_gap_pct  = 0;
        res_stall_pct = 0;
      end
      if (p == 2) begin
        s = '{eval_ticks: 8'd255, check_ticks: 8'd255, holdoff_ticks: 8'd255,
              jump_delta: 7'd127, temp_low: 7'd127, temp_mid: 7'd127, temp_high: 7'd127,
              policy_bits: 8'hFF};
        s.policy_bits[7] = 1'b0;
      end else begin
        s = random_setting();
      end
      apply_setting(s);
      for (int n = 0; n < 80; n++) begin
        r = $urandom_range(0, 99);
        if (r < 8) begin
          temp_walk = $urandom_range(0, 127);
        end else if (r < 18) begin
          temp_walk = temp_walk + int'(cur_setting.jump_delta) + $urandom_range(1, 12);
        end else begin
          temp_walk = temp_walk + $urandom_range(0, 8) - 4;
        end
        if (temp_walk < 0) temp_walk = 0;
        if (temp_walk > 127) temp_walk = 127;
        f = ($urandom_range(0, 99) < 60) ? int'(fan_follow) : $urandom_range(0, 3);
        send_tick(7'(temp_walk), 2'(f));
      end
    end

    drain();
    repeat (8) @(posedge clk_i);

    $display("Covered %0d tick words over %0d register settings and three idling regimes;",
             ticks_sent, settings_used);
    $display("%0d result words checked, %0d fan commands among them.",
             words_checked, cmds_seen);
    if (fail_count == 0 && pending_words == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

[thermal_fan_step_controller.f]
+incdir+hw/rtl
hw/rtl/tfsc_pkg.sv
hw/rtl/tfsc_if.sv
hw/rtl/tfsc_cfg_regs.sv
hw/rtl/tfsc_step.sv
hw/rtl/thermal_fan_step_controller.sv
tb/tfsc_step_checker.sv
tb/tb_top.sv
